>>> rtl/core/rwc_pkg.sv
package rwc_pkg;

    // Frame and kernel limits
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MAX_RADIUS     = 2;
    localparam int COEF_FRAC_BITS = 11;

    localparam int KSIZE  = 2 * MAX_RADIUS + 1;
    localparam int LINES  = KSIZE - 1;
    localparam int DIM_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = 2 * DIM_W;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int COEF_W = 12;
    localparam int PROD_W = CH_W + COEF_W;
    localparam int RSUM_W = PROD_W + $clog2(KSIZE);
    localparam int SUM_W  = RSUM_W + $clog2(KSIZE);
    localparam int ROW_BITS = KSIZE * COEF_W;
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Register indexes
    localparam logic [2:0] REG_RADIUS     = 3'd0;
    localparam logic [2:0] REG_WIDTH      = 3'd1;
    localparam logic [2:0] REG_HEIGHT     = 3'd2;
    localparam logic [2:0] REG_COEF_ROW_0 = 3'd3;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [ROW_BITS-1:0] coef_row_t;
    typedef coef_row_t [KSIZE-1:0] kernel_t;

    typedef struct packed {
        logic [1:0]       radius;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } geom_t;

    typedef struct packed {
        pixel_t [KSIZE-1:0] column;
        logic [KSIZE-1:0]   row_ok;
        logic [KSIZE-1:0]   col_ok;
        logic               emit;
        logic               last;
    } qentry_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [QCNT_W-1:0]  count;
    } qstat_t;

    function automatic logic [COEF_W-1:0] coef_at(kernel_t kernel, int ri, int ci);
        logic [COEF_W-1:0] c;
        c = '0;
        if (ri >= 0 && ri < KSIZE && ci >= 0 && ci < KSIZE)
        begin
            c = kernel[ri][ci*COEF_W +: COEF_W];
        end
        return c;
    endfunction

endpackage

>>> rtl/core/rwc_ram.sv
module rwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/rwc_front.sv
module rwc_front
    import rwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  geom_t             geom,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [CH_W-1:0]   in_blue,
    input  logic [CH_W-1:0]   in_green,
    input  logic [CH_W-1:0]   in_red,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output qentry_t           q_entry
);

    typedef pixel_t [LINES-1:0] lines_t;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] ox_reg, ox_next;
    logic [ROW_W-1:0] oy_reg, oy_next;

    logic             f1_valid_reg;
    logic [COL_W-1:0] f1_col_reg;
    pixel_t           f1_pix_reg;
    logic [KSIZE-1:0] f1_row_ok_reg, f1_col_ok_reg;
    logic             f1_emit_reg, f1_last_reg;

    logic             prev_valid_reg;
    logic [COL_W-1:0] prev_col_reg;
    lines_t           prev_data_reg;

    logic [CNT_W-1:0] n_pos, lag_pos, end_pos, cnt_eff;
    logic [COL_W-1:0] col_eff, ox_eff;
    logic [ROW_W-1:0] oy_eff;
    logic             restart, accept, emit, last;
    pixel_t           pix;
    logic [ROW_W:0]   ytop;
    logic [COL_W:0]   xtop;
    logic [KSIZE-1:0] row_ok, col_ok;
    lines_t           rd_data, old_data, wr_data;

    assign accept   = in_valid && in_ready;
    assign in_ready = (int'(q_count) + int'(f1_valid_reg)) < QDEPTH;

    // Classify the request against the frame position
    always_comb
    begin
        n_pos   = CNT_W'(geom.width) * CNT_W'(geom.height);
        lag_pos = CNT_W'(geom.radius) * CNT_W'(geom.width) + CNT_W'(geom.radius);
        end_pos = n_pos + lag_pos;
        restart = count_reg >= end_pos;
        cnt_eff = restart ? '0 : count_reg;
        col_eff = restart ? '0 : col_reg;
        ox_eff  = restart ? '0 : ox_reg;
        oy_eff  = restart ? '0 : oy_reg;

        pix = '0;
        if (!mode && cnt_eff < n_pos)
        begin
            pix = {in_red, in_green, in_blue};
        end
        emit = cnt_eff >= lag_pos;
        last = emit && ({1'b0, ox_eff} == geom.width - DIM_W'(1))
                    && ({1'b0, oy_eff} == geom.height - DIM_W'(1));

        ytop = {1'b0, oy_eff} + (ROW_W+1)'(geom.radius);
        xtop = {1'b0, ox_eff} + (COL_W+1)'(geom.radius);
        for (int k = 0; k < KSIZE; k++)
        begin
            row_ok[k] = (k <= 2 * int'(geom.radius)) && (int'(ytop) >= k)
                        && (int'(ytop) < int'(geom.height) + k);
            col_ok[k] = (k <= 2 * int'(geom.radius)) && (int'(xtop) >= k)
                        && (int'(xtop) < int'(geom.width) + k);
        end

        count_next = cnt_eff + CNT_W'(1);
        col_next   = ({1'b0, col_eff} == geom.width - DIM_W'(1)) ? '0 : col_eff + COL_W'(1);
        ox_next    = ox_eff;
        oy_next    = oy_eff;
        if (emit)
        begin
            if ({1'b0, ox_eff} == geom.width - DIM_W'(1))
            begin
                ox_next = '0;
                oy_next = oy_eff + ROW_W'(1);
            end
            else
            begin
                ox_next = ox_eff + COL_W'(1);
            end
        end
        if (last)
        begin
            count_next = '0;
            col_next   = '0;
            ox_next    = '0;
            oy_next    = '0;
        end
    end

    // Advance position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            col_reg        <= '0;
            ox_reg         <= '0;
            oy_reg         <= '0;
            f1_valid_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                col_reg   <= col_next;
                ox_reg    <= ox_next;
                oy_reg    <= oy_next;
            end
            f1_valid_reg   <= accept;
            prev_valid_reg <= f1_valid_reg;
        end
    end

    // Hold the request while the line buffer read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_col_reg    <= col_eff;
            f1_pix_reg    <= pix;
            f1_row_ok_reg <= row_ok;
            f1_col_ok_reg <= col_ok;
            f1_emit_reg   <= emit;
            f1_last_reg   <= last;
        end
        prev_col_reg  <= f1_col_reg;
        prev_data_reg <= wr_data;
    end

    rwc_ram #(
        .WIDTH (LINES * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (f1_valid_reg),
        .waddr (f1_col_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (col_eff),
        .rdata (rd_data)
    );

    // Forward the write still in flight, then shift the lines down by one row
    always_comb
    begin
        old_data = (prev_valid_reg && prev_col_reg == f1_col_reg) ? prev_data_reg : rd_data;
        wr_data[0] = f1_pix_reg;
        for (int i = 1; i < LINES; i++)
        begin
            wr_data[i] = old_data[i-1];
        end
        q_entry.column[0] = f1_pix_reg;
        for (int i = 1; i < KSIZE; i++)
        begin
            q_entry.column[i] = old_data[i-1];
        end
        q_entry.row_ok = f1_row_ok_reg;
        q_entry.col_ok = f1_col_ok_reg;
        q_entry.emit   = f1_emit_reg;
        q_entry.last   = f1_last_reg;
    end

    assign q_push = f1_valid_reg;

endmodule

>>> rtl/core/rwc_queue.sv
module rwc_queue
    import rwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qentry_t           push_entry,
    input  logic              pop,
    output qentry_t           pop_entry,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(QDEPTH);

    qentry_t           slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assign pop_entry = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> rtl/core/rwc_back.sv
module rwc_back
    import rwc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      radius,
    input  kernel_t         kernel,
    input  logic            q_valid,
    input  qentry_t         q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CH_W-1:0] out_blue,
    output logic [CH_W-1:0] out_green,
    output logic [CH_W-1:0] out_red,
    output logic            frame_last
);

    pixel_t               win_reg [KSIZE][KSIZE];
    logic                 w_valid_reg, w_last_reg;
    logic [KSIZE-1:0]     w_row_ok_reg, w_col_ok_reg;
    logic [PROD_W-1:0]    prod_reg [KSIZE][KSIZE][3];
    logic                 m_valid_reg, m_last_reg;
    logic [RSUM_W-1:0]    rsum_reg [KSIZE][3];
    logic                 s_valid_reg, s_last_reg;
    logic                 o_valid_reg, o_last_reg;
    logic [CH_W-1:0]      o_ch_reg [3];

    logic                 adv;
    logic [PROD_W-1:0]    prod_next [KSIZE][KSIZE][3];
    logic [RSUM_W-1:0]    rsum_next [KSIZE][3];
    logic [CH_W-1:0]      ch_next [3];
    logic [SUM_W-1:0]     total;
    logic [SUM_W-COEF_FRAC_BITS-1:0] scaled;
    logic [COEF_W-1:0]    c;

    assign adv   = !o_valid_reg || out_ready;
    assign q_pop = q_valid && adv;

    // Shift the window by one column per request
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int k = 0; k < KSIZE; k++)
            begin
                win_reg[k][0] <= q_entry.column[k];
                for (int j = 1; j < KSIZE; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
            w_row_ok_reg <= q_entry.row_ok;
            w_col_ok_reg <= q_entry.col_ok;
            w_last_reg   <= q_entry.last;
        end
        if (adv)
        begin
            prod_reg   <= prod_next;
            m_last_reg <= w_last_reg;
            rsum_reg   <= rsum_next;
            s_last_reg <= m_last_reg;
            o_ch_reg   <= ch_next;
            o_last_reg <= s_last_reg;
        end
    end

    // Multiply each tap by its coefficient; drop taps outside the image
    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                c = coef_at(kernel, int'(radius) + MAX_RADIUS - k,
                            int'(radius) + MAX_RADIUS - j);
                for (int ch = 0; ch < 3; ch++)
                begin
                    prod_next[k][j][ch] = (w_row_ok_reg[k] && w_col_ok_reg[j])
                        ? PROD_W'(win_reg[k][j][ch*CH_W +: CH_W]) * PROD_W'(c)
                        : '0;
                end
            end
        end
    end

    // Sum each kernel row
    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rsum_next[k][ch] = '0;
                for (int j = 0; j < KSIZE; j++)
                begin
                    rsum_next[k][ch] = rsum_next[k][ch] + RSUM_W'(prod_reg[k][j][ch]);
                end
            end
        end
    end

    // Sum rows, truncate and saturate
    always_comb
    begin
        total  = '0;
        scaled = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            total = '0;
            for (int k = 0; k < KSIZE; k++)
            begin
                total = total + SUM_W'(rsum_reg[k][ch]);
            end
            scaled = total[SUM_W-1:COEF_FRAC_BITS];
            ch_next[ch] = (scaled > (SUM_W-COEF_FRAC_BITS)'(CH_MAX))
                          ? CH_MAX : scaled[CH_W-1:0];
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_valid_reg <= q_pop && q_entry.emit;
            m_valid_reg <= w_valid_reg;
            s_valid_reg <= m_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_blue   = o_ch_reg[0];
    assign out_green  = o_ch_reg[1];
    assign out_red    = o_ch_reg[2];
    assign frame_last = o_last_reg;

endmodule

>>> rtl/core/rgb_window_convolution_unit.sv
// Path: the request that completes a window passes the line buffer read,
// queue, window shift, multiply, row sum and final sum stages in that order.
// Throughput: one request per cycle, set by the line buffer read-modify-write
// with forwarding; output stalls back up through the queue.
// Reset: rst_n clears counters, queue and valid flags; the line buffer is not
// cleared, since taps outside the image are masked by position.
module rgb_window_convolution_unit
    import rwc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [ROW_BITS-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [CH_W-1:0]    in_blue,
    input  logic [CH_W-1:0]    in_green,
    input  logic [CH_W-1:0]    in_red,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CH_W-1:0]    out_blue,
    output logic [CH_W-1:0]    out_green,
    output logic [CH_W-1:0]    out_red,
    output logic               frame_last
);

    logic [1:0]       radius_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    kernel_t          kernel_reg;
    geom_t            geom;
    qentry_t          push_entry, pop_entry;
    qstat_t           qstat;
    logic             q_valid;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            width_reg  <= DIM_W'(512);
            height_reg <= DIM_W'(512);
            kernel_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_RADIUS)
            begin
                radius_reg <= cfg_data[1:0];
            end
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data[DIM_W-1:0];
            end
            for (int i = 0; i < KSIZE; i++)
            begin
                if (cfg_index == REG_COEF_ROW_0 + 3'(i))
                begin
                    kernel_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Clamp geometry to the supported range
    always_comb
    begin
        geom.radius = (int'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
        geom.width  = (width_reg == '0) ? DIM_W'(1)
                    : (int'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
        geom.height = (height_reg == '0) ? DIM_W'(1)
                    : (int'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;
    end

    rwc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .in_blue  (in_blue),
        .in_green (in_green),
        .in_red   (in_red),
        .q_count  (qstat.count),
        .q_push   (qstat.push),
        .q_entry  (push_entry)
    );

    rwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (qstat.push),
        .push_entry (push_entry),
        .pop        (qstat.pop),
        .pop_entry  (pop_entry),
        .count      (qstat.count)
    );

    assign q_valid = qstat.count != '0;

    rwc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius     (geom.radius),
        .kernel     (kernel_reg),
        .q_valid    (q_valid),
        .q_entry    (pop_entry),
        .q_pop      (qstat.pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .frame_last (frame_last)
    );

    // Queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.push && !qstat.pop |-> int'(qstat.count) < QDEPTH)
        else $error("request queue overflow");

    // Queue never pops when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.pop |-> qstat.count != '0)
        else $error("request queue underflow");

    // Accepted request always reaches the queue next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> qstat.push)
        else $error("accepted request not pushed");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rwc_pkg::*;

    localparam int RING = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;

    typedef struct {
        bit       drain;
        bit [7:0] b;
        bit [7:0] g;
        bit [7:0] r;
    } pixel_req_t;

    typedef struct {
        bit [7:0] b;
        bit [7:0] g;
        bit [7:0] r;
        bit       last;
    } filtered_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [ROW_BITS-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic mode = 0;
    logic [CH_W-1:0] in_blue = '0, in_green = '0, in_red = '0;
    logic out_valid;
    logic out_ready = 0;
    logic [CH_W-1:0] out_blue, out_green, out_red;
    logic frame_last;

    rgb_window_convolution_unit dut (.*);

    always #1 clk = ~clk;

    // shadow of the block's registers and pixel history
    bit [1:0]          radius_reg = 0;
    bit [DIM_W-1:0]    width_reg = 512;
    bit [DIM_W-1:0]    height_reg = 512;
    bit [ROW_BITS-1:0] coef_rows [5];
    bit [23:0]         pixel_ring [RING];
    int                stream_pos = 0;

    pixel_req_t pixel_q[$];
    filtered_t  filtered_q[$];
    int fails = 0;
    int sent_cnt = 0;
    int recv_cnt = 0;
    bit req_taken = 0;
    int holdoff = 0;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic int eff_radius();
        return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    endfunction

    function automatic bit [7:0] clip_sum(longint unsigned s);
        longint unsigned v;
        v = s >> COEF_FRAC_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // store one request and work out the filtered pixel it releases
    function automatic void filter_step(pixel_req_t req);
        int w, h, rad, n, lag, p, x, y, yy, xx, q;
        longint unsigned sb, sg, sr, c;
        bit [23:0] v;
        filtered_t res;
        w = eff_width();
        h = eff_height();
        rad = eff_radius();
        n = w * h;
        lag = rad * w + rad;
        sb = 0;
        sg = 0;
        sr = 0;
        if (stream_pos >= n + lag) stream_pos = 0;
        v = (!req.drain && stream_pos < n) ? {req.r, req.g, req.b} : 24'd0;
        pixel_ring[stream_pos % RING] = v;
        if (stream_pos < lag)
        begin
            stream_pos++;
            return;
        end
        p = stream_pos - lag;
        y = p / w;
        x = p % w;
        for (int dy = -rad; dy <= rad; dy++)
        begin
            yy = y + dy;
            if (yy < 0 || yy >= h) continue;
            for (int dx = -rad; dx <= rad; dx++)
            begin
                xx = x + dx;
                if (xx < 0 || xx >= w) continue;
                q = yy * w + xx;
                v = pixel_ring[q % RING];
                c = 64'(coef_rows[dy + 2][12 * (dx + 2) +: 12]);
                sb += v[7:0] * c;
                sg += v[15:8] * c;
                sr += v[23:16] * c;
            end
        end
        res.b = clip_sum(sb);
        res.g = clip_sum(sg);
        res.r = clip_sum(sr);
        res.last = (p == n - 1);
        stream_pos = res.last ? 0 : stream_pos + 1;
        filtered_q.push_back(res);
    endfunction

    // sender: accept at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            filter_step('{mode, in_blue, in_green, in_red});
            req_taken = 1;
            sent_cnt++;
        end
    end

    always @(negedge clk)
    begin
        if (!in_valid || req_taken)
        begin
            pixel_req_t nx;
            req_taken = 0;
            if (pixel_q.size() > 0 && rst_n &&
                ((sent_cnt > 500 && sent_cnt < 900) || $urandom_range(99) >= 12))
            begin
                nx = pixel_q.pop_front();
                mode <= nx.drain;
                in_blue <= nx.b;
                in_green <= nx.g;
                in_red <= nx.r;
                in_valid <= 1;
            end
            else
            begin
                in_valid <= 0;
            end
        end
    end

    // receiver: check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            filtered_t e;
            recv_cnt++;
            if (filtered_q.size() == 0)
            begin
                $error("unexpected result");
                fails++;
            end
            else
            begin
                e = filtered_q.pop_front();
                if (out_blue !== e.b)
                begin
                    $error("out_blue exp %0d got %0d", e.b, out_blue);
                    fails++;
                end
                if (out_green !== e.g)
                begin
                    $error("out_green exp %0d got %0d", e.g, out_green);
                    fails++;
                end
                if (out_red !== e.r)
                begin
                    $error("out_red exp %0d got %0d", e.r, out_red);
                    fails++;
                end
                if (frame_last !== e.last)
                begin
                    $error("frame_last exp %0d got %0d", e.last, frame_last);
                    fails++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_cnt == 200 && holdoff == 0)
            holdoff = 400;
        if (holdoff > 1)
        begin
            holdoff--;
            out_ready <= 0;
        end
        else
        begin
            if (holdoff == 1) holdoff = -1;
            out_ready <= rst_n && ((recv_cnt > 700 && recv_cnt < 1000) ||
                                   $urandom_range(99) >= 12);
        end
    end

    task automatic write_reg(bit [2:0] idx, bit [ROW_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_RADIUS: radius_reg = val[1:0];
            REG_WIDTH:  width_reg = val[DIM_W-1:0];
            REG_HEIGHT: height_reg = val[DIM_W-1:0];
            default:    coef_rows[idx - REG_COEF_ROW_0] = val;
        endcase
    endtask

    // kind 0 random, 1 small, 2 all max, 3 zero, 4 identity
    function automatic bit [ROW_BITS-1:0] coef_row(int kind, int row);
        bit [ROW_BITS-1:0] v;
        v = '0;
        for (int k = 0; k < KSIZE; k++)
        begin
            case (kind)
                0: v[12 * k +: 12] = 12'($urandom_range(4095));
                1: v[12 * k +: 12] = 12'($urandom_range(120));
                2: v[12 * k +: 12] = 12'hFFF;
                4: v[12 * k +: 12] = (row == 2 && k == 2) ? 12'h800 : 12'h000;
                default: v[12 * k +: 12] = 12'h000;
            endcase
        end
        return v;
    endfunction

    // wait until idle, then load a whole setting
    task automatic configure(int rad, int w, int h, int kind);
        wait (pixel_q.size() == 0 && !in_valid && filtered_q.size() == 0);
        repeat (12) @(posedge clk);
        write_reg(REG_RADIUS, ROW_BITS'(rad));
        write_reg(REG_WIDTH, ROW_BITS'(w));
        write_reg(REG_HEIGHT, ROW_BITS'(h));
        for (int i = 0; i < KSIZE; i++)
            write_reg(REG_COEF_ROW_0 + 3'(i), coef_row(kind, i));
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic bit [7:0] chan_val(int style);
        case (style)
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'hAA;
            3: return 8'h55;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one frame followed by its drain requests
    task automatic queue_frame(int style);
        int n, lag;
        pixel_req_t pr;
        n = eff_width() * eff_height();
        lag = eff_radius() * eff_width() + eff_radius();
        for (int i = 0; i < n + lag; i++)
        begin
            pr.b = chan_val(style < 0 ? i % 5 : style);
            pr.g = chan_val(style < 0 ? (i + 1) % 5 : style);
            pr.r = chan_val(style < 0 ? (i + 2) % 5 : style);
            if (i < n)
                pr.drain = ($urandom_range(99) < 5);
            else
                pr.drain = ($urandom_range(99) >= 20);
            pixel_q.push_back(pr);
        end
    endtask

    initial
    begin
        int rad, w, h;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: saturation, identity, extreme and degenerate geometry
        configure(2, 5, 4, 2);
        queue_frame(-1);
        configure(0, 4, 3, 4);
        queue_frame(-1);
        configure(0, 2047, 1, 1);
        queue_frame(4);
        configure(1, 0, 0, 0);
        queue_frame(1);
        configure(3, 3, 3, 1);
        queue_frame(1);

        // random frames, mostly small
        while (sent_cnt < 1500)
        begin
            rad = $urandom_range(3);
            w = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if (w > 64) h = $urandom_range(1, 2);
            configure(rad, w, h, $urandom_range(4));
            queue_frame(4);
        end

        wait (pixel_q.size() == 0 && !in_valid && filtered_q.size() == 0);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
